FILE: design/svau_pkg.sv
package svau_pkg;

  typedef enum logic [1:0] {
    FMT_FP32 = 2'd0,
    FMT_FP16 = 2'd1,
    FMT_BF16 = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  localparam logic [31:0] QUIET_BIT      = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN    = 32'hFFC0_0000;
  localparam logic [31:0] POS_INF        = 32'h7F80_0000;
  localparam logic [31:0] BF16_ROUND_ADD = 32'h0000_8000;
  localparam int          HALF_SHIFT     = 16;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SCALE  = 1'b1;

  // y operand and last flag riding alongside the multiplier
  typedef struct packed {
    logic [31:0] y;
    logic        last;
  } side_t;

  function automatic logic is_nan(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] == 23'd0);
  endfunction

  function automatic logic [5:0] msb48(input logic [47:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) r = i[5:0];
    end
    return r;
  endfunction

  function automatic logic [4:0] msb28(input logic [27:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) r = i[4:0];
    end
    return r;
  endfunction

  // Round to nearest even and pack; e is the biased exponent, at least 1.
  // A mantissa without hidden bit packs as subnormal; carries roll into
  // the exponent and up to infinity.
  function automatic logic [31:0] round_pack(input logic s, input logic [9:0] e,
                                             input logic [23:0] m, input logic g,
                                             input logic st);
    logic        inc;
    logic [7:0]  fld;
    logic [30:0] mag;
    inc = g & (st | m[0]);
    fld = m[23] ? e[7:0] : 8'd0;
    mag = {fld, m[22:0]} + {30'd0, inc};
    if (e >= 10'd255) return {s, POS_INF[30:0]};
    return {s, mag};
  endfunction

endpackage

FILE: design/scaled_vector_add_unit.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+-------------------------------------
// input     | start (busy always low)      | x_element, y_element, last_in
// result    | done, one-cycle strobe       | sum_element, last_out
// config    | APB psel/penable/pwrite      | paddr, pwdata, prdata (pready high)
//
// One item is taken every cycle; each result passes through one widening
// stage, four multiplier stages (24x24 product, leading one search,
// normalize, round), four adder stages (align, add, leading one search,
// normalize and round) and one narrowing stage.
// rst is synchronous and clears the valid chain and both registers.
// The receiver cannot stall, so the pipeline never holds.
module scaled_vector_add_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_element,
  input  logic [31:0] y_element,
  input  logic        last_in,
  output logic        done,
  output logic [31:0] sum_element,
  output logic        last_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  svau_pkg::fmt_t  number_format;
  logic [31:0]     scale_factor;

  logic            w_valid;
  logic [31:0]     xw, yw;
  logic            w_last;
  logic [31:0]     xw_next, yw_next;

  logic            m_valid;
  logic [31:0]     m_prod;
  svau_pkg::side_t m_side;
  svau_pkg::side_t w_side;

  logic            a_valid;
  logic [31:0]     a_sum;
  logic            a_last;
  logic [31:0]     sum_next;

  // Widen fp16 exactly to fp32; subnormals renormalize.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [3:0]  sh;
    logic [7:0]  e32;
    logic [9:0]  mn;
    s = {h[15], 31'd0};
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = i[3:0];
    end
    sh  = 4'd10 - p;
    e32 = 8'd103 + {4'd0, p};
    mn  = m << sh;
    if (e == 5'h1F) return s | svau_pkg::POS_INF | {9'd0, m, 13'd0};
    if (e == 5'd0) begin
      if (m == 10'd0) return s;
      return s | {1'b0, e32, mn, 13'd0};
    end
    return s | {1'b0, {3'd0, e} + 8'd112, m, 13'd0};
  endfunction

  // Narrow fp32 to fp16 with round to nearest even.
  function automatic logic [15:0] single_to_half(input logic [31:0] u);
    logic [15:0] s;
    logic [7:0]  e;
    logic [22:0] m;
    logic signed [9:0] he;
    logic [15:0] val;
    logic [12:0] rem13;
    logic [23:0] full, rem, half, msk;
    logic [9:0]  shw;
    logic [4:0]  sh;
    s  = {u[31], 15'd0};
    e  = u[30:23];
    m  = u[22:0];
    he = $signed({2'd0, e}) - 10'sd112;
    shw = 10'd14 - he[9:0];
    sh  = shw[4:0];
    full = {1'b1, m};
    msk  = (24'd1 << sh) - 24'd1;
    rem  = full & msk;
    half = 24'd1 << (sh - 5'd1);
    rem13 = m[12:0];
    if (e == 8'hFF) begin
      if (m != 23'd0) return s | 16'h7E00 | {6'd0, m[22:13]};
      return s | 16'h7C00;
    end
    if (he >= 10'sd31) return s | 16'h7C00;
    if (he >= 10'sd1) begin
      val = {1'b0, he[4:0], m[22:13]};
      if ((rem13 > 13'h1000) || ((rem13 == 13'h1000) && val[0])) val = val + 16'd1;
      return s | val;
    end
    if (e == 8'd0) return s;
    if (shw > 10'd24) return s;
    val = 16'(full >> sh);
    if ((rem > half) || ((rem == half) && val[0])) val = val + 16'd1;
    return s | val;
  endfunction

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Config: write at the access phase, read back as stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= svau_pkg::FMT_FP32;
      scale_factor  <= 32'h3F80_0000;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        svau_pkg::REG_FORMAT: number_format <= svau_pkg::fmt_t'(pwdata[1:0]);
        svau_pkg::REG_SCALE:  scale_factor  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      svau_pkg::REG_FORMAT: prdata = {30'd0, number_format};
      svau_pkg::REG_SCALE:  prdata = scale_factor;
      default:              prdata = 32'd0;
    endcase
  end

  // Widen operands to fp32; the reserved code behaves as fp32.
  always_comb begin
    case (number_format)
      svau_pkg::FMT_FP16: begin
        xw_next = half_to_single(x_element[15:0]);
        yw_next = half_to_single(y_element[15:0]);
      end
      svau_pkg::FMT_BF16: begin
        xw_next = {x_element[15:0], 16'd0};
        yw_next = {y_element[15:0], 16'd0};
      end
      default: begin
        xw_next = x_element;
        yw_next = y_element;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    xw     <= xw_next;
    yw     <= yw_next;
    w_last <= last_in;
  end

  assign w_side = '{y: yw, last: w_last};

  svau_fmul u_fmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w_valid),
    .a         (xw),
    .b         (scale_factor),
    .in_side   (w_side),
    .out_valid (m_valid),
    .prod      (m_prod),
    .out_side  (m_side)
  );

  svau_fadd u_fadd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .a         (m_side.y),
    .b         (m_prod),
    .in_last   (m_side.last),
    .out_valid (a_valid),
    .sum       (a_sum),
    .out_last  (a_last)
  );

  // Narrow the fp32 sum back to the element format.
  always_comb begin
    case (number_format)
      svau_pkg::FMT_FP16: sum_next = {16'd0, single_to_half(a_sum)};
      svau_pkg::FMT_BF16: sum_next = {16'd0, 16'((a_sum + svau_pkg::BF16_ROUND_ADD)
                                                 >> svau_pkg::HALF_SHIFT)};
      default:            sum_next = a_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_element <= sum_next;
    last_out    <= a_last;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##10 done)
    else $error("result strobe missing at fixed latency");

  a_narrow_upper: assert property (@(posedge clk) disable iff (rst)
    (done && ((number_format == svau_pkg::FMT_FP16) ||
              (number_format == svau_pkg::FMT_BF16))) |-> (sum_element[31:16] == 16'd0))
    else $error("upper bits set on 16-bit result");

  a_quiet_nan: assert property (@(posedge clk) disable iff (rst)
    (done && (number_format == svau_pkg::FMT_FP32) && svau_pkg::is_nan(sum_element))
      |-> sum_element[22])
    else $error("signaling NaN on fp32 result");
`endif

endmodule

FILE: design/svau_fmul.sv
module svau_fmul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  input  svau_pkg::side_t      in_side,
  output logic                 out_valid,
  output logic [31:0]          prod,
  output svau_pkg::side_t      out_side
);

  logic                v1, v2, v3, v4;
  svau_pkg::side_t     side1, side2, side3, side4;
  logic                spec1, spec2, spec3;
  logic [31:0]         sv1, sv2, sv3;
  logic                s1, s2, s3;
  logic [8:0]          es1, es2;
  logic [47:0]         p1, p2, pn3;
  logic [5:0]          l2, d3;
  logic [9:0]          ec3;
  logic [31:0]         prod4;

  logic                spec_c, sgn_c, az, bz;
  logic [31:0]         sv_c;
  logic [7:0]          ea, eb;
  logic [23:0]         ma, mb;
  logic signed [10:0]  ee, dn;
  logic [5:0]          d_c;
  logic [9:0]          ec_c;
  logic [47:0]         sh, mask;
  logic                lost;

  always_comb begin
    sgn_c  = a[31] ^ b[31];
    az     = (a[30:0] == 31'd0);
    bz     = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    spec_c = 1'b1;
    if (svau_pkg::is_nan(a)) begin
      sv_c = a | svau_pkg::QUIET_BIT;
    end else if (svau_pkg::is_nan(b)) begin
      sv_c = b | svau_pkg::QUIET_BIT;
    end else if ((svau_pkg::is_inf(a) && bz) || (svau_pkg::is_inf(b) && az)) begin
      sv_c = svau_pkg::DEFAULT_NAN;
    end else if (svau_pkg::is_inf(a) || svau_pkg::is_inf(b)) begin
      sv_c = {sgn_c, svau_pkg::POS_INF[30:0]};
    end else if (az || bz) begin
      sv_c = {sgn_c, 31'd0};
    end else begin
      sv_c   = 32'd0;
      spec_c = 1'b0;
    end
  end

  always_comb begin
    ee = $signed({5'd0, l2}) + $signed({2'd0, es2}) - 11'sd173;
    dn = 11'sd1 - ee;
    if (ee < 11'sd1) begin
      ec_c = 10'd1;
      d_c  = (dn > 11'sd48) ? 6'd48 : dn[5:0];
    end else begin
      ec_c = ee[9:0];
      d_c  = 6'd0;
    end
  end

  always_comb begin
    sh    = pn3 >> d3;
    mask  = (48'd1 << d3) - 48'd1;
    lost  = |(pn3 & mask);
    prod4 = spec3 ? sv3 :
            svau_pkg::round_pack(s3, ec3, sh[47:24], sh[23], (|sh[22:0]) | lost);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    side1 <= in_side;
    spec1 <= spec_c;
    sv1   <= sv_c;
    s1    <= sgn_c;
    es1   <= {1'b0, ea} + {1'b0, eb};
    p1    <= ma * mb;

    side2 <= side1;
    spec2 <= spec1;
    sv2   <= sv1;
    s2    <= s1;
    es2   <= es1;
    p2    <= p1;
    l2    <= svau_pkg::msb48(p1);

    side3 <= side2;
    spec3 <= spec2;
    sv3   <= sv2;
    s3    <= s2;
    pn3   <= p2 << (6'd47 - l2);
    d3    <= d_c;
    ec3   <= ec_c;

    side4 <= side3;
    prod  <= prod4;
  end

  assign out_valid = v4;
  assign out_side  = side4;

endmodule

FILE: design/svau_fadd.sv
module svau_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        in_last,
  output logic        out_valid,
  output logic [31:0] sum,
  output logic        out_last
);

  logic        v1, v2, v3, v4;
  logic        last1, last2, last3, last4;
  logic        spec1, spec2, spec3;
  logic [31:0] sv1, sv2, sv3;
  logic        s1, s2, s3;
  logic        sub1, sub2, sub3;
  logic [7:0]  e1, e2, e3;
  logic [26:0] mb1, al1;
  logic [27:0] sm2, sm3;
  logic [4:0]  l3;

  logic        spec_c;
  logic [31:0] sv_c, big, sml;
  logic [7:0]  eb, es, d;
  logic [4:0]  dd;
  logic [26:0] ms, mask, al;

  logic [4:0]  sn, shl;
  logic [7:0]  lim;
  logic [26:0] n;
  logic [9:0]  ef;
  logic [31:0] res;

  always_comb begin
    spec_c = 1'b1;
    if (svau_pkg::is_nan(a)) begin
      sv_c = a | svau_pkg::QUIET_BIT;
    end else if (svau_pkg::is_nan(b)) begin
      sv_c = b | svau_pkg::QUIET_BIT;
    end else if (svau_pkg::is_inf(a) && svau_pkg::is_inf(b) && (a[31] != b[31])) begin
      sv_c = svau_pkg::DEFAULT_NAN;
    end else if (svau_pkg::is_inf(a)) begin
      sv_c = a;
    end else if (svau_pkg::is_inf(b)) begin
      sv_c = b;
    end else begin
      sv_c   = 32'd0;
      spec_c = 1'b0;
    end
    big  = (a[30:0] >= b[30:0]) ? a : b;
    sml  = (a[30:0] >= b[30:0]) ? b : a;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = eb - es;
    dd   = (d > 8'd27) ? 5'd27 : d[4:0];
    ms   = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
    mask = (27'd1 << dd) - 27'd1;
    al   = ms >> dd;
    al[0] = al[0] | (|(ms & mask));
  end

  always_comb begin
    sn  = 5'd26 - l3;
    lim = e3 - 8'd1;
    shl = ({3'd0, sn} > lim) ? lim[4:0] : sn;
    if (l3 == 5'd27) begin
      n  = {sm3[27:2], sm3[1] | sm3[0]};
      ef = {2'd0, e3} + 10'd1;
    end else begin
      n  = sm3[26:0] << shl;
      ef = {2'd0, e3} - {5'd0, shl};
    end
    if (spec3) begin
      res = sv3;
    end else if (sm3 == 28'd0) begin
      res = sub3 ? 32'd0 : {s3, 31'd0};
    end else begin
      res = svau_pkg::round_pack(s3, ef, n[26:3], n[2], |n[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    last1 <= in_last;
    spec1 <= spec_c;
    sv1   <= sv_c;
    s1    <= big[31];
    sub1  <= a[31] ^ b[31];
    e1    <= eb;
    mb1   <= {big[30:23] != 8'd0, big[22:0], 3'd0};
    al1   <= al;

    last2 <= last1;
    spec2 <= spec1;
    sv2   <= sv1;
    s2    <= s1;
    sub2  <= sub1;
    e2    <= e1;
    sm2   <= sub1 ? ({1'b0, mb1} - {1'b0, al1}) : ({1'b0, mb1} + {1'b0, al1});

    last3 <= last2;
    spec3 <= spec2;
    sv3   <= sv2;
    s3    <= s2;
    sub3  <= sub2;
    e3    <= e2;
    sm3   <= sm2;
    l3    <= svau_pkg::msb28(sm2);

    last4 <= last3;
    sum   <= res;
  end

  assign out_valid = v4;
  assign out_last  = last4;

endmodule
